FILE: src/dnsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsq_pkg
// Shared types and constants of the DNS query packet encoder.
// ----------------------------------------------------------------------------
package dnsq_pkg;

    // Input command codes
    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_CHAR    = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_TRAILER = 2'd3;

    localparam logic [7:0] DOT_CHAR = 8'd46;

    localparam int HDR_BYTES = 12;
    localparam int TRL_BYTES = 5;
    localparam int DATA_W    = 8 * HDR_BYTES;

    // Work class assigned by the front end
    typedef enum logic [2:0] {
        K_HDR  = 3'd0,
        K_CHAR = 3'd1,
        K_DOT  = 3'd2,
        K_END  = 3'd3,
        K_TRL  = 3'd4
    } t_kind;

    // One queued command: header words or trailer words or the character
    typedef struct packed {
        t_kind               kind;
        logic [DATA_W-1:0]   data;
    } t_entry;

endpackage
`default_nettype wire

FILE: src/dnsq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsq_front
// Accepts input transactions, classifies the command and packs the payload.
// ----------------------------------------------------------------------------
module dnsq_front (
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_command,
    input  wire logic [15:0]         i_query_id,
    input  wire logic [15:0]         i_header_flags,
    input  wire logic [15:0]         i_question_count,
    input  wire logic [15:0]         i_answer_count,
    input  wire logic [15:0]         i_authority_count,
    input  wire logic [15:0]         i_additional_count,
    input  wire logic [7:0]          i_name_char,
    input  wire logic [15:0]         i_query_type,
    input  wire logic [15:0]         i_query_class,
    input  wire logic                i_full,
    output logic                     o_push,
    output dnsq_pkg::t_entry         o_entry
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_entry = '0;
        unique case (i_command)
            dnsq_pkg::CMD_HEADER: begin
                o_entry.kind = dnsq_pkg::K_HDR;
                o_entry.data = {i_query_id, i_header_flags, i_question_count,
                                i_answer_count, i_authority_count, i_additional_count};
            end
            dnsq_pkg::CMD_CHAR: begin
                o_entry.kind = (i_name_char == dnsq_pkg::DOT_CHAR) ?
                               dnsq_pkg::K_DOT : dnsq_pkg::K_CHAR;
                o_entry.data = {{(dnsq_pkg::DATA_W-8){1'b0}}, i_name_char};
            end
            dnsq_pkg::CMD_END: begin
                o_entry.kind = dnsq_pkg::K_END;
            end
            dnsq_pkg::CMD_TRAILER: begin
                o_entry.kind = dnsq_pkg::K_TRL;
                o_entry.data = {{(dnsq_pkg::DATA_W-32){1'b0}}, i_query_type, i_query_class};
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/dnsq_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsq_queue
// Small command FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module dnsq_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire dnsq_pkg::t_entry           i_entry,
    input  wire logic                       i_pop,
    output dnsq_pkg::t_entry                o_head,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    dnsq_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

FILE: src/dnsq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsq_back
// Byte sequencer: label store, header/trailer/label byte emission, output reg.
// ----------------------------------------------------------------------------
module dnsq_back #(
    parameter int LABEL_MAX = 63
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dnsq_pkg::t_entry   i_head,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_byte,
    output logic                    o_last,
    output logic                    o_ovf,
    output logic                    o_is_label
);

    localparam int LENW = $clog2(LABEL_MAX+1);
    localparam int AW   = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_TRL  = 4'b0100,
        S_LBL  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [3:0]      r_cnt, n_cnt;
    logic [LENW-1:0] r_len, n_len;
    logic            r_lovf, n_lovf;
    logic [LENW-1:0] r_flen, n_flen;
    logic            r_fovf, n_fovf;
    logic [LENW-1:0] r_idx, n_idx;

    logic [7:0]      r_store [LABEL_MAX];
    logic [7:0]      r_rd_data;

    logic            r_ovalid, r_olast, r_oovf, r_olabel;
    logic [7:0]      r_obyte;

    logic            w_ld, w_wr_en, w_rd_en, w_emit;
    logic [AW-1:0]   w_rd_addr;
    logic [7:0]      w_byte;
    logic            w_last, w_ovf, w_label;

    logic [dnsq_pkg::HDR_BYTES-1:0][7:0] w_hdr;
    logic [3:0][7:0]                     w_trl;

    assign w_hdr = i_head.data;
    assign w_trl = i_head.data[31:0];
    assign w_ld  = !r_ovalid || i_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_lovf    = r_lovf;
        n_flen    = r_flen;
        n_fovf    = r_fovf;
        n_idx     = r_idx;
        o_pop     = 1'b0;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_emit    = 1'b0;
        w_byte    = '0;
        w_last    = 1'b0;
        w_ovf     = 1'b0;
        w_label   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.kind)
                        dnsq_pkg::K_CHAR: begin
                            o_pop = 1'b1;
                            if (r_len < LENW'(LABEL_MAX)) begin
                                w_wr_en = 1'b1;
                                n_len   = r_len + 1'b1;
                            end else begin
                                n_lovf = 1'b1;
                            end
                        end
                        dnsq_pkg::K_DOT, dnsq_pkg::K_END: begin
                            if (i_head.kind == dnsq_pkg::K_END && r_len == '0) begin
                                // empty name end: nothing to flush
                                o_pop  = 1'b1;
                                n_lovf = 1'b0;
                            end else if (w_ld) begin
                                o_pop     = 1'b1;
                                w_emit    = 1'b1;
                                w_byte    = {{(8-LENW){1'b0}}, r_len};
                                w_last    = (r_len == '0);
                                w_ovf     = r_lovf;
                                w_label   = 1'b1;
                                w_rd_en   = 1'b1;
                                w_rd_addr = '0;
                                n_flen    = r_len;
                                n_fovf    = r_lovf;
                                n_idx     = LENW'(1);
                                n_len     = '0;
                                n_lovf    = 1'b0;
                                if (r_len != '0) begin
                                    n_state = S_LBL;
                                end
                            end
                        end
                        dnsq_pkg::K_HDR: begin
                            if (w_ld) begin
                                w_emit  = 1'b1;
                                w_byte  = w_hdr[dnsq_pkg::HDR_BYTES-1];
                                n_cnt   = 4'd1;
                                n_len   = '0;
                                n_lovf  = 1'b0;
                                n_state = S_HDR;
                            end
                        end
                        dnsq_pkg::K_TRL: begin
                            if (w_ld) begin
                                w_emit  = 1'b1;
                                w_byte  = 8'd0;
                                n_cnt   = 4'd1;
                                n_len   = '0;
                                n_lovf  = 1'b0;
                                n_state = S_TRL;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_byte = w_hdr[4'(dnsq_pkg::HDR_BYTES-1) - r_cnt];
                    w_last = (r_cnt == 4'(dnsq_pkg::HDR_BYTES-1));
                    n_cnt  = r_cnt + 1'b1;
                    if (w_last) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_TRL: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_byte = w_trl[2'(4'(dnsq_pkg::TRL_BYTES-1) - r_cnt)];
                    w_last = (r_cnt == 4'(dnsq_pkg::TRL_BYTES-1));
                    n_cnt  = r_cnt + 1'b1;
                    if (w_last) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_LBL: begin
                if (w_ld) begin
                    w_emit  = 1'b1;
                    w_byte  = r_rd_data;
                    w_ovf   = r_fovf;
                    w_label = 1'b1;
                    w_last  = (r_idx == r_flen);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx[AW-1:0];
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_lovf   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_lovf  <= n_lovf;
            if (w_ld) begin
                r_ovalid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_flen <= n_flen;
        r_fovf <= n_fovf;
        r_idx  <= n_idx;
        if (w_ld && w_emit) begin
            r_obyte  <= w_byte;
            r_olast  <= w_last;
            r_oovf   <= w_ovf;
            r_olabel <= w_label;
        end
    end

    // label store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[r_len[AW-1:0]] <= i_head.data[7:0];
        end
        if (w_rd_en) begin
            r_rd_data <= r_store[w_rd_addr];
        end
    end

    assign o_valid    = r_ovalid;
    assign o_byte     = r_obyte;
    assign o_last     = r_olast;
    assign o_ovf      = r_oovf;
    assign o_is_label = r_olabel;

endmodule
`default_nettype wire

FILE: src/dns_query_packet_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_packet_encoder_core
// DNS query wire-format encoder: header, dotted-name labels, trailer.
// ----------------------------------------------------------------------------
// Each input transaction carries one command. A header command produces the
// twelve header bytes (six 16-bit words, big-endian); name characters are
// collected into a LABEL_MAX-entry label store and produce nothing; a dot,
// or an end-of-name command with a pending label, produces the length byte
// and then the stored characters; a trailer produces the zero terminator and
// query type/class big-endian. o_run_last marks the final byte of each
// command. Characters beyond LABEL_MAX are dropped and every byte of that
// label carries o_label_overflow. Timing: the front end accepts one
// transaction per cycle, while the queue is not full, into a
// QUEUE_DEPTH-entry command queue; the byte sequencer behind it stores name
// characters without output and emits one output byte per cycle while the
// receiver is ready. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module dns_query_packet_encoder_core #(
    parameter int LABEL_MAX   = 63,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input channel
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_command,
    input  wire logic [15:0]   i_query_id,
    input  wire logic [15:0]   i_header_flags,
    input  wire logic [15:0]   i_question_count,
    input  wire logic [15:0]   i_answer_count,
    input  wire logic [15:0]   i_authority_count,
    input  wire logic [15:0]   i_additional_count,
    input  wire logic [7:0]    i_name_char,
    input  wire logic [15:0]   i_query_type,
    input  wire logic [15:0]   i_query_class,
    // output channel
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_label_overflow
);

    localparam int QCW = $clog2(QUEUE_DEPTH+1);

    dnsq_pkg::t_entry w_entry, w_head;
    logic             w_push, w_pop, w_full, w_empty, w_is_label;
    logic [QCW-1:0]   w_q_count;

    // Front: accept and classify
    dnsq_front u_front (
        .i_valid            (i_in_valid),
        .o_ready            (o_in_ready),
        .i_command          (i_command),
        .i_query_id         (i_query_id),
        .i_header_flags     (i_header_flags),
        .i_question_count   (i_question_count),
        .i_answer_count     (i_answer_count),
        .i_authority_count  (i_authority_count),
        .i_additional_count (i_additional_count),
        .i_name_char        (i_name_char),
        .i_query_type       (i_query_type),
        .i_query_class      (i_query_class),
        .i_full             (w_full),
        .o_push             (w_push),
        .o_entry            (w_entry)
    );

    // Decoupling queue
    dnsq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_count (w_q_count)
    );

    // Back: label store and byte sequencer with output register
    dnsq_back #(
        .LABEL_MAX (LABEL_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_byte     (o_out_byte),
        .o_last     (o_run_last),
        .o_ovf      (o_label_overflow),
        .o_is_label (w_is_label)
    );

    // Sequencer never retires a command that is not queued
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

    // A full queue must back-pressure the input
    a_full_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_count == QCW'(QUEUE_DEPTH)) |-> !o_in_ready)
        else $error("input ready while queue full");

    // Overflow marking only ever appears on label bytes
    a_ovf_label_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !w_is_label) |-> !o_label_overflow)
        else $error("overflow flag on header or trailer byte");

endmodule
`default_nettype wire

FILE: verif/dns_query_packet_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_packet_encoder_checker
// Scoreboard for the DNS query encoder: tracks label state from accepted
// commands, queues the wire bytes each one must produce and compares every
// accepted output byte against the oldest queued one.
// ----------------------------------------------------------------------------
module dns_query_packet_encoder_checker #(
    parameter int LABEL_MAX = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_query_id,
    input  wire logic [15:0] i_header_flags,
    input  wire logic [15:0] i_question_count,
    input  wire logic [15:0] i_answer_count,
    input  wire logic [15:0] i_authority_count,
    input  wire logic [15:0] i_additional_count,
    input  wire logic [7:0]  i_name_char,
    input  wire logic [15:0] i_query_type,
    input  wire logic [15:0] i_query_class,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_run_last,
    input  wire logic        i_label_overflow,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_bytes_checked,
    output int               o_cut_labels
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_wire_byte;

    t_wire_byte  wire_bytes_q[$];
    logic [7:0]  label_chars [0:62];
    logic [5:0]  lbl_count = '0;
    logic        label_cut = 1'b0;
    int          fails = 0;
    int          checked = 0;
    int          cut_labels = 0;

    function automatic void push_byte(input logic [7:0] b, input logic ovf);
        t_wire_byte e;
        e.data = b;
        e.last = 1'b0;
        e.ovf  = ovf;
        wire_bytes_q = {wire_bytes_q, e};
    endfunction

    function automatic void push_word(input logic [15:0] w);
        push_byte(w[15:8], 1'b0);
        push_byte(w[7:0], 1'b0);
    endfunction

    function automatic void flush_label();
        push_byte({2'b00, lbl_count}, label_cut);
        for (int i = 0; i < lbl_count; i++)
            push_byte(label_chars[i], label_cut);
        if (label_cut)
            cut_labels++;
        lbl_count = '0;
        label_cut = 1'b0;
    endfunction

    // Queues the bytes one command produces; the final one carries last.
    function automatic void encode_command(
        input logic [1:0]  cmd,
        input logic [15:0] id,
        input logic [15:0] flags,
        input logic [15:0] qd,
        input logic [15:0] an,
        input logic [15:0] ns,
        input logic [15:0] ar,
        input logic [7:0]  ch,
        input logic [15:0] qtype,
        input logic [15:0] qclass
    );
        int base;
        base = wire_bytes_q.size();
        case (cmd)
            dnsq_pkg::CMD_HEADER: begin
                lbl_count = '0;
                label_cut = 1'b0;
                push_word(id);
                push_word(flags);
                push_word(qd);
                push_word(an);
                push_word(ns);
                push_word(ar);
            end
            dnsq_pkg::CMD_CHAR: begin
                if (ch == dnsq_pkg::DOT_CHAR) begin
                    flush_label();
                end else if (lbl_count < LABEL_MAX) begin
                    label_chars[lbl_count] = ch;
                    lbl_count = lbl_count + 6'd1;
                end else begin
                    label_cut = 1'b1;
                end
            end
            dnsq_pkg::CMD_END: begin
                if (lbl_count != 0) begin
                    flush_label();
                end else begin
                    label_cut = 1'b0;
                end
            end
            default: begin
                lbl_count = '0;
                label_cut = 1'b0;
                push_byte(8'h00, 1'b0);
                push_word(qtype);
                push_word(qclass);
            end
        endcase
        if (wire_bytes_q.size() > base)
            wire_bytes_q[wire_bytes_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_wire_byte exp_byte;
        if (!i_rst_n) begin
            wire_bytes_q.delete();
            lbl_count = '0;
            label_cut = 1'b0;
        end else begin
            // outputs first: a byte leaving now never stems from this edge's input
            if (i_out_valid && i_out_ready) begin
                if (wire_bytes_q.size() == 0) begin
                    fails++;
                    $error("unexpected output byte: out_byte 0x%02h", i_out_byte);
                end else begin
                    exp_byte = wire_bytes_q.pop_front();
                    checked++;
                    if (i_out_byte !== exp_byte.data) begin
                        fails++;
                        $error("out_byte mismatch: expected 0x%02h, got 0x%02h",
                               exp_byte.data, i_out_byte);
                    end
                    if (i_run_last !== exp_byte.last) begin
                        fails++;
                        $error("run_last mismatch: expected %0b, got %0b",
                               exp_byte.last, i_run_last);
                    end
                    if (i_label_overflow !== exp_byte.ovf) begin
                        fails++;
                        $error("label_overflow mismatch: expected %0b, got %0b",
                               exp_byte.ovf, i_label_overflow);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                encode_command(i_command, i_query_id, i_header_flags,
                               i_question_count, i_answer_count,
                               i_authority_count, i_additional_count,
                               i_name_char, i_query_type, i_query_class);
        end
        o_pending       <= wire_bytes_q.size();
        o_fail_count    <= fails;
        o_bytes_checked <= checked;
        o_cut_labels    <= cut_labels;
    end

endmodule

FILE: verif/dns_query_packet_encoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_packet_encoder_core_test
// Drives header, name and trailer commands into the DNS query encoder under
// several flow-control regimes; a side checker predicts and compares bytes.
// ----------------------------------------------------------------------------
module dns_query_packet_encoder_core_test;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_ITEMS  = 10;
    localparam int TAIL_CYCLES  = 32;

    // how the 16-bit header / trailer fields get filled
    localparam int FILL_ZERO = 0;
    localparam int FILL_ONES = 1;
    localparam int FILL_RAND = 2;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  in_command;
    logic [15:0] in_query_id;
    logic [15:0] in_header_flags;
    logic [15:0] in_question_count;
    logic [15:0] in_answer_count;
    logic [15:0] in_authority_count;
    logic [15:0] in_additional_count;
    logic [7:0]  in_name_char;
    logic [15:0] in_query_type;
    logic [15:0] in_query_class;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        label_overflow;

    int fail_count;
    int bytes_pending;
    int bytes_checked;
    int cut_labels;

    // idle / stall percentages; stall is read by the ready driver
    int idle_pct;
    int cur_idle;
    int stall_now;
    int cmd_count [4];

    always #(HALF_PERIOD) clk = ~clk;

    dns_query_packet_encoder_core uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_command          (in_command),
        .i_query_id         (in_query_id),
        .i_header_flags     (in_header_flags),
        .i_question_count   (in_question_count),
        .i_answer_count     (in_answer_count),
        .i_authority_count  (in_authority_count),
        .i_additional_count (in_additional_count),
        .i_name_char        (in_name_char),
        .i_query_type       (in_query_type),
        .i_query_class      (in_query_class),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_out_byte         (out_byte),
        .o_run_last         (run_last),
        .o_label_overflow   (label_overflow)
    );

    dns_query_packet_encoder_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_command          (in_command),
        .i_query_id         (in_query_id),
        .i_header_flags     (in_header_flags),
        .i_question_count   (in_question_count),
        .i_answer_count     (in_answer_count),
        .i_authority_count  (in_authority_count),
        .i_additional_count (in_additional_count),
        .i_name_char        (in_name_char),
        .i_query_type       (in_query_type),
        .i_query_class      (in_query_class),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_out_byte         (out_byte),
        .i_run_last         (run_last),
        .i_label_overflow   (label_overflow),
        .o_fail_count       (fail_count),
        .o_pending          (bytes_pending),
        .o_bytes_checked    (bytes_checked),
        .o_cut_labels       (cut_labels)
    );

    // Receiver back-pressure: fresh coin each cycle.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_now);
    end

    function automatic logic [15:0] fill_word(input int mode);
        if (mode == FILL_ZERO)
            return 16'h0000;
        if (mode == FILL_ONES)
            return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Any character except the dot, so it lands in the label store.
    function automatic logic [7:0] label_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == dnsq_pkg::DOT_CHAR)
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // Offer one transaction after a random gap; returns at the accepting edge
    // with valid still high, so the next call may keep it asserted.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input int fill);
        while ($urandom_range(99) < cur_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_command          <= cmd;
        in_name_char        <= ch;
        in_query_id         <= fill_word(fill);
        in_header_flags     <= fill_word(fill);
        in_question_count   <= fill_word(fill);
        in_answer_count     <= fill_word(fill);
        in_authority_count  <= fill_word(fill);
        in_additional_count <= fill_word(fill);
        in_query_type       <= fill_word(fill);
        in_query_class      <= fill_word(fill);
        in_valid            <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cmd_count[cmd]++;
    endtask

    // Sender holds off until the checker has seen every predicted byte.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
    endtask

    task automatic send_label(input int len);
        for (int i = 0; i < len; i++)
            send_item(dnsq_pkg::CMD_CHAR, label_char(), FILL_RAND);
    endtask

    // One query with random content; a fraction is noise or malformed.
    task automatic send_packet();
        int n_labels;
        int len;
        if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? dnsq_pkg::DOT_CHAR
                                                   : 8'($urandom_range(255)),
                          FILL_RAND);
        end
        if ($urandom_range(7) != 0)
            send_item(dnsq_pkg::CMD_HEADER, 8'($urandom_range(255)), FILL_RAND);
        n_labels = $urandom_range(0, 4);
        for (int l = 0; l < n_labels; l++) begin
            // mostly short labels, now and then one near, at or past the limit
            len = ($urandom_range(39) == 0) ? $urandom_range(60, 68)
                                            : $urandom_range(0, 8);
            send_label(len);
            if (l != n_labels - 1)
                send_item(dnsq_pkg::CMD_CHAR, dnsq_pkg::DOT_CHAR, FILL_RAND);
            else if ($urandom_range(3) == 0)
                send_item(dnsq_pkg::CMD_CHAR, dnsq_pkg::DOT_CHAR, FILL_RAND);
        end
        if ($urandom_range(9) != 0)
            send_item(dnsq_pkg::CMD_END, 8'($urandom_range(255)), FILL_RAND);
        if ($urandom_range(7) != 0)
            send_item(dnsq_pkg::CMD_TRAILER, 8'($urandom_range(255)), FILL_RAND);
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        int start_items;
        start_items = cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3];
        idle_pct = sender_idle;
        while (cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3]
               - start_items < PHASE_ITEMS) begin
            // occasional packet with no idling on either side
            if ($urandom_range(5) == 0) begin
                cur_idle = 0;
                stall_now <= 0;
            end else begin
                cur_idle = idle_pct;
                stall_now <= receiver_stall;
            end
            send_packet();
        end
        wait_drained();
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        foreach (cmd_count[i])
            cmd_count[i] = 0;
        idle_pct = 0;
        cur_idle = 0;
        rst_n               <= 1'b0;
        stall_now           <= 0;
        in_valid            <= 1'b0;
        in_command          <= dnsq_pkg::CMD_HEADER;
        in_query_id         <= '0;
        in_header_flags     <= '0;
        in_question_count   <= '0;
        in_answer_count     <= '0;
        in_authority_count  <= '0;
        in_additional_count <= '0;
        in_name_char        <= '0;
        in_query_type       <= '0;
        in_query_class      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, empty labels, pending label discarded.
        send_item(dnsq_pkg::CMD_HEADER, 8'h00, FILL_ZERO);
        send_item(dnsq_pkg::CMD_CHAR, "w", FILL_ZERO);
        send_item(dnsq_pkg::CMD_CHAR, "w", FILL_ZERO);
        send_item(dnsq_pkg::CMD_CHAR, dnsq_pkg::DOT_CHAR, FILL_ZERO);
        send_item(dnsq_pkg::CMD_CHAR, dnsq_pkg::DOT_CHAR, FILL_ONES); // dot on empty label
        send_item(dnsq_pkg::CMD_CHAR, 8'h00, FILL_ONES);
        send_item(dnsq_pkg::CMD_CHAR, 8'hFF, FILL_ONES);
        send_item(dnsq_pkg::CMD_END, 8'hFF, FILL_ONES);
        send_item(dnsq_pkg::CMD_END, dnsq_pkg::DOT_CHAR, FILL_ZERO);  // nothing pending
        send_item(dnsq_pkg::CMD_TRAILER, 8'hFF, FILL_ONES);
        send_item(dnsq_pkg::CMD_HEADER, 8'hFF, FILL_ONES);
        send_item(dnsq_pkg::CMD_CHAR, "x", FILL_RAND);
        send_item(dnsq_pkg::CMD_HEADER, 8'h00, FILL_RAND);   // drops pending "x"
        send_item(dnsq_pkg::CMD_CHAR, "y", FILL_RAND);
        send_item(dnsq_pkg::CMD_TRAILER, 8'h00, FILL_RAND);  // drops pending "y"
        send_item(dnsq_pkg::CMD_END, 8'h00, FILL_RAND);
        send_item(dnsq_pkg::CMD_TRAILER, 8'h00, FILL_ZERO);
        wait_drained();

        // Label at exactly the limit, then one that gets cut.
        send_label(63);
        send_item(dnsq_pkg::CMD_CHAR, dnsq_pkg::DOT_CHAR, FILL_RAND);
        send_label(66);
        send_item(dnsq_pkg::CMD_END, 8'h00, FILL_RAND);
        wait_drained();

        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(24, 24);

        while (bytes_pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d headers, %0d name characters, %0d ends, %0d trailers",
                 cmd_count[dnsq_pkg::CMD_HEADER], cmd_count[dnsq_pkg::CMD_CHAR],
                 cmd_count[dnsq_pkg::CMD_END], cmd_count[dnsq_pkg::CMD_TRAILER]);
        $display("over four flow-control regimes; %0d bytes compared, %0d cut labels",
                 bytes_checked, cut_labels);
        if (fail_count == 0 && bytes_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
